// File: hdl/json_string_unescape_utf8_defines.svh
// Assertion helpers for the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication.
`define JSU_ASSERT_NOW(name, ck, rs, cond, expr) \
  name: assert property (@(posedge ck) disable iff (rs) (cond) |-> (expr)) \
    else $error("jsu: assertion failed");

// Next-cycle implication.
`define JSU_ASSERT_NEXT(name, ck, rs, cond, expr) \
  name: assert property (@(posedge ck) disable iff (rs) (cond) |=> (expr)) \
    else $error("jsu: assertion failed");

`endif

// File: hdl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int CpW       = 21;
  localparam int HeldDepth = 5;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChFormFeed  = 8'h0C;

  localparam logic [15:0] SurHiMin = 16'hD800;
  localparam logic [15:0] SurHiMax = 16'hDBFF;
  localparam logic [15:0] SurLoMin = 16'hDC00;
  localparam logic [15:0] SurLoMax = 16'hDFFF;
  localparam logic [CpW-1:0] SupplBase = 21'h10000;

  localparam logic [CpW-1:0] Max1Byte = 21'h00007F;
  localparam logic [CpW-1:0] Max2Byte = 21'h0007FF;
  localparam logic [CpW-1:0] Max3Byte = 21'h00FFFF;

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] Cont  = 8'h80;

  // raw: emit value[7:0] as is; otherwise UTF-8 encode value
  typedef struct packed {
    logic           raw;
    logic [CpW-1:0] value;
  } item_t;

  typedef enum logic [1:0] {
    SRC_SLOT,
    SRC_REP,
    SRC_MARK
  } src_t;

  typedef struct packed {
    logic load;
    logic slot_step;
    logic rep_step;
    logic out_load;
    logic out_end;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic room;
    logic slot_busy;
    logic slot_more;
    logic rep_any;
    logic rep_emit;
    logic rep_more;
    logic ending;
  } sts_t;

  function automatic item_t make_raw(logic [7:0] b);
    item_t it;
    it.raw   = 1'b1;
    it.value = {13'd0, b};
    return it;
  endfunction

  function automatic item_t make_cp(logic [CpW-1:0] v);
    item_t it;
    it.raw   = 1'b0;
    it.value = v;
    return it;
  endfunction

  // byte count minus one
  function automatic logic [1:0] cp_len(item_t it);
    logic [1:0] n;
    if (it.raw || it.value <= Max1Byte) begin
      n = 2'd0;
    end else if (it.value <= Max2Byte) begin
      n = 2'd1;
    end else if (it.value <= Max3Byte) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] cp_byte(item_t it, logic [1:0] k);
    logic [1:0]     n;
    logic [CpW-1:0] v;
    logic [7:0]     r;
    n = cp_len(it);
    v = it.value;
    r = v[7:0];
    unique case (n)
      2'd0: r = v[7:0];
      2'd1: r = (k == 2'd0) ? (Lead2 | {3'd0, v[10:6]}) : (Cont | {2'd0, v[5:0]});
      2'd2: begin
        unique case (k)
          2'd0:    r = Lead3 | {4'd0, v[15:12]};
          2'd1:    r = Cont | {2'd0, v[11:6]};
          default: r = Cont | {2'd0, v[5:0]};
        endcase
      end
      default: begin
        unique case (k)
          2'd0:    r = Lead4 | {5'd0, v[20:18]};
          2'd1:    r = Cont | {2'd0, v[17:12]};
          2'd2:    r = Cont | {2'd0, v[11:6]};
          default: r = Cont | {2'd0, v[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      ChLowerN: r = ChNewline;
      ChLowerR: r = ChReturn;
      ChLowerT: r = ChTab;
      ChLowerB: r = ChBackspace;
      ChLowerF: r = ChFormFeed;
      default:  r = c;
    endcase
    return r;
  endfunction

  // {bad, digit}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

endpackage

// File: hdl/json_string_unescape_utf8.sv
// JSON string unescaper: takes the raw body bytes of one string token, one word per byte with
// last_byte on the final one, and returns the unescaped text as UTF-8, one byte per output word,
// with string_end on the last word of the token (a word with byte_valid low if no byte is left).
// An input word occupies the block until its output words are produced; in an end-of-token replay
// each dropped \u also takes a step that emits no byte. The output side drains one byte per cycle
// through a single output register, and the next input word is taken in the cycle that produces
// the current word's final byte. Plain text therefore streams at one byte per cycle while the output
// is not stalled; a \u escape takes one cycle per input byte, its final digit one cycle per UTF-8
// byte it yields (four for a joined pair), and the final word of a token that ends inside an escape
// replays up to five held bytes from the held-byte shift line, one step per cycle.
// Output backpressure stalls the input accordingly.
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       string_end
);

  jsu_pkg::cmd_t cmd;
  jsu_pkg::sts_t sts;

  jsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jsu_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .string_end (string_end)
  );

  `JSU_ASSERT_NOW(a_load_has_room, clk, rst, cmd.out_load, sts.room)
  `JSU_ASSERT_NOW(a_marker_ends, clk, rst, out_valid && !byte_valid, string_end)
  `JSU_ASSERT_NOW(a_silent_not_final, clk, rst, cmd.rep_step && !sts.rep_emit, sts.rep_more)
  `JSU_ASSERT_NEXT(a_replay_drained, clk, rst, cmd.rep_step && !sts.rep_more, !sts.rep_any)

endmodule

// File: hdl/jsu_ctrl.sv
`timescale 1ns / 1ps

module jsu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::sts_t sts,
  output jsu_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_SLOT,
    ST_REPLAY
  } state_t;

  state_t state;
  state_t state_next;
  logic   done;

  always_comb begin
    done          = 1'b0;
    cmd.load      = 1'b0;
    cmd.slot_step = 1'b0;
    cmd.rep_step  = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.out_end   = 1'b0;
    cmd.src       = jsu_pkg::SRC_SLOT;
    unique case (state)
      ST_WAIT: done = 1'b1;
      ST_SLOT: begin
        if (sts.slot_busy) begin
          if (sts.room) begin
            cmd.slot_step = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_end   = sts.ending && !sts.slot_more && !sts.rep_any;
            done          = !sts.slot_more && !sts.rep_any;
          end
        end else if (!sts.rep_any && !sts.ending) begin
          done = 1'b1;
        end
      end
      ST_REPLAY: begin
        if (sts.rep_any) begin
          if (sts.room) begin
            cmd.rep_step = 1'b1;
            cmd.out_load = sts.rep_emit;
            cmd.src      = jsu_pkg::SRC_REP;
            cmd.out_end  = sts.ending && !sts.rep_more;
            done         = !sts.rep_more;
          end
        end else if (sts.ending) begin
          // bare end marker
          if (sts.room) begin
            cmd.out_load = 1'b1;
            cmd.src      = jsu_pkg::SRC_MARK;
            cmd.out_end  = 1'b1;
            done         = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
    in_ready = done;
    cmd.load = in_valid && done;
  end

  always_comb begin
    state_next = state;
    if (cmd.load) begin
      state_next = ST_SLOT;
    end else if (done) begin
      state_next = ST_WAIT;
    end else if (state == ST_SLOT &&
                 (!sts.slot_busy || (cmd.slot_step && !sts.slot_more))) begin
      state_next = ST_REPLAY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/jsu_datapath.sv
`timescale 1ns / 1ps

module jsu_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          last_byte,
  input  logic          out_ready,
  input  jsu_pkg::cmd_t cmd,
  output jsu_pkg::sts_t sts,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          string_end
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_HEX,
    PH_PAIR
  } phase_t;

  // decoder state
  phase_t      phase;
  logic [15:0] accum;
  logic        hinv;
  logic [9:0]  hs;
  logic [2:0]  hcnt;
  logic [jsu_pkg::HeldDepth*8-1:0] held_vec;

  phase_t      phase_next;
  logic [15:0] accum_next;
  logic        hinv_next;
  logic [9:0]  hs_next;
  logic [2:0]  hcnt_next;
  logic        held_we;

  // per-word output list
  jsu_pkg::item_t slot_a, slot_b, slot_c;
  logic [2:0]     mask;
  logic [1:0]     bidx;
  logic [2:0]     rep_cnt;
  logic           ending;

  jsu_pkg::item_t a_item, b_item, c_item;
  logic           a_v, b_v, c_v;
  logic [2:0]     rep_load;

  // decode helpers
  logic [4:0]     dig;
  logic [15:0]    acc_val;
  logic           inv_val;
  logic           set_pair;
  logic           lo_ok;
  jsu_pkg::item_t set_item, high_item, pair_item, esc_item, raw_item;
  logic           esc_u;
  logic           idle_esc;

  assign dig       = jsu_pkg::hex_digit(in_byte);
  assign acc_val   = dig[4] ? accum : {accum[11:0], dig[3:0]};
  assign inv_val   = hinv | dig[4];
  assign set_pair  = !inv_val && acc_val >= jsu_pkg::SurHiMin && acc_val <= jsu_pkg::SurHiMax;
  assign lo_ok     = !inv_val && acc_val >= jsu_pkg::SurLoMin && acc_val <= jsu_pkg::SurLoMax;
  assign set_item  = inv_val ? jsu_pkg::make_raw(jsu_pkg::ChQuestion)
                             : jsu_pkg::make_cp({5'd0, acc_val});
  assign high_item = jsu_pkg::make_cp({5'd0, jsu_pkg::SurHiMin[15:10], hs});
  assign pair_item = jsu_pkg::make_cp(jsu_pkg::SupplBase + {1'b0, hs, acc_val[9:0]});
  assign esc_u     = in_byte == jsu_pkg::ChLowerU;
  assign esc_item  = jsu_pkg::make_raw(jsu_pkg::esc_map(in_byte));
  assign raw_item  = jsu_pkg::make_raw(in_byte);
  assign idle_esc  = in_byte == jsu_pkg::ChBackslash && !last_byte;

  always_comb begin
    phase_next = phase;
    accum_next = accum;
    hinv_next  = hinv;
    hs_next    = hs;
    hcnt_next  = hcnt;
    held_we    = 1'b0;
    a_v        = 1'b0;
    a_item     = raw_item;
    b_v        = 1'b0;
    b_item     = raw_item;
    unique case (phase)
      PH_IDLE: begin
        phase_next = idle_esc ? PH_ESC : PH_IDLE;
        a_v        = !idle_esc;
      end
      PH_ESC: begin
        if (esc_u) begin
          phase_next = PH_HEX;
          hcnt_next  = 3'd0;
          accum_next = 16'd0;
          hinv_next  = 1'b0;
        end else begin
          phase_next = PH_IDLE;
          a_v        = 1'b1;
          a_item     = esc_item;
        end
      end
      PH_HEX: begin
        accum_next = acc_val;
        hinv_next  = inv_val;
        if (hcnt < 3'd3) begin
          held_we   = 1'b1;
          hcnt_next = hcnt + 3'd1;
        end else begin
          hcnt_next = 3'd0;
          if (set_pair) begin
            phase_next = PH_PAIR;
            hs_next    = acc_val[9:0];
            accum_next = 16'd0;
            hinv_next  = 1'b0;
          end else begin
            phase_next = PH_IDLE;
            a_v        = 1'b1;
            a_item     = set_item;
          end
        end
      end
      PH_PAIR: begin
        if (hcnt == 3'd0 && in_byte != jsu_pkg::ChBackslash) begin
          // no escape follows the high surrogate
          phase_next = PH_IDLE;
          a_v        = 1'b1;
          a_item     = high_item;
          b_v        = 1'b1;
        end else if (hcnt == 3'd1 && !esc_u) begin
          phase_next = PH_IDLE;
          hcnt_next  = 3'd0;
          a_v        = 1'b1;
          a_item     = high_item;
          b_v        = 1'b1;
          b_item     = esc_item;
        end else if (hcnt < 3'd5) begin
          if (hcnt >= 3'd2) begin
            accum_next = acc_val;
            hinv_next  = inv_val;
          end
          held_we   = 1'b1;
          hcnt_next = hcnt + 3'd1;
        end else begin
          accum_next = acc_val;
          hinv_next  = inv_val;
          hcnt_next  = 3'd0;
          a_v        = 1'b1;
          if (lo_ok) begin
            phase_next = PH_IDLE;
            a_item     = pair_item;
          end else begin
            a_item = high_item;
            if (set_pair) begin
              phase_next = PH_PAIR;
              hs_next    = acc_val[9:0];
              accum_next = 16'd0;
              hinv_next  = 1'b0;
            end else begin
              phase_next = PH_IDLE;
              b_v        = 1'b1;
              b_item     = set_item;
            end
          end
        end
      end
    endcase
  end

  // end-of-string tail
  always_comb begin
    c_v      = 1'b0;
    c_item   = jsu_pkg::make_raw(jsu_pkg::ChBackslash);
    rep_load = 3'd0;
    if (last_byte) begin
      if (phase_next == PH_PAIR) begin
        c_v      = 1'b1;
        c_item   = jsu_pkg::make_cp({5'd0, jsu_pkg::SurHiMin[15:10], hs_next});
        rep_load = hcnt_next;
      end else if (phase_next == PH_HEX) begin
        rep_load = hcnt_next;
      end else if (phase_next == PH_ESC) begin
        c_v = 1'b1;
      end
    end
  end

  // slot sequencing
  jsu_pkg::item_t cur_item;
  logic [2:0]     cur_hot;
  logic [1:0]     cur_len;

  always_comb begin
    priority if (mask[0]) begin
      cur_item = slot_a;
      cur_hot  = 3'b001;
    end else if (mask[1]) begin
      cur_item = slot_b;
      cur_hot  = 3'b010;
    end else begin
      cur_item = slot_c;
      cur_hot  = 3'b100;
    end
  end

  assign cur_len = jsu_pkg::cp_len(cur_item);

  // replay over held bytes, consumed from the bottom
  logic [7:0] h0, h1, h2, h3, h4;
  logic       p01, p12, p23, p34;
  logic       tok2;
  logic [2:0] rem_after;
  logic       empty_now;
  logic       empty_after;
  logic [7:0] rep_byte;

  assign h0 = held_vec[7:0];
  assign h1 = held_vec[15:8];
  assign h2 = held_vec[23:16];
  assign h3 = held_vec[31:24];
  assign h4 = held_vec[39:32];

  assign p01 = h0 == jsu_pkg::ChBackslash && h1 == jsu_pkg::ChLowerU;
  assign p12 = h1 == jsu_pkg::ChBackslash && h2 == jsu_pkg::ChLowerU;
  assign p23 = h2 == jsu_pkg::ChBackslash && h3 == jsu_pkg::ChLowerU;
  assign p34 = h3 == jsu_pkg::ChBackslash && h4 == jsu_pkg::ChLowerU;

  assign tok2      = h0 == jsu_pkg::ChBackslash && rep_cnt >= 3'd2;
  assign rem_after = rep_cnt - (tok2 ? 3'd2 : 3'd1);
  assign empty_now = rep_cnt == 3'd0 || (rep_cnt == 3'd2 && p01) ||
                     (rep_cnt == 3'd4 && p01 && p23);
  assign empty_after = tok2 ? (rem_after == 3'd0 || (rem_after == 3'd2 && p23))
                            : (rem_after == 3'd0 || (rem_after == 3'd2 && p12) ||
                               (rem_after == 3'd4 && p12 && p34));
  assign rep_byte = tok2 ? jsu_pkg::esc_map(h1) : h0;

  assign sts.room      = !out_valid || out_ready;
  assign sts.slot_busy = mask != 3'd0;
  assign sts.slot_more = bidx != cur_len || (mask & ~cur_hot) != 3'd0;
  assign sts.rep_any   = !empty_now;
  assign sts.rep_emit  = !tok2 || h1 != jsu_pkg::ChLowerU;
  assign sts.rep_more  = !empty_after;
  assign sts.ending    = ending;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      accum     <= 16'd0;
      hinv      <= 1'b0;
      hs        <= 10'd0;
      hcnt      <= 3'd0;
      mask      <= 3'd0;
      bidx      <= 2'd0;
      rep_cnt   <= 3'd0;
      ending    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (last_byte) begin
          phase <= PH_IDLE;
          accum <= 16'd0;
          hinv  <= 1'b0;
          hs    <= 10'd0;
          hcnt  <= 3'd0;
        end else begin
          phase <= phase_next;
          accum <= accum_next;
          hinv  <= hinv_next;
          hs    <= hs_next;
          hcnt  <= hcnt_next;
        end
        mask    <= {c_v, b_v, a_v};
        bidx    <= 2'd0;
        rep_cnt <= rep_load;
        ending  <= last_byte;
      end else begin
        if (cmd.slot_step) begin
          if (bidx == cur_len) begin
            mask <= mask & ~cur_hot;
            bidx <= 2'd0;
          end else begin
            bidx <= bidx + 2'd1;
          end
        end
        if (cmd.rep_step) begin
          rep_cnt <= rem_after;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_a <= a_item;
      slot_b <= b_item;
      slot_c <= c_item;
    end
    if (cmd.load && held_we) begin
      held_vec[{hcnt, 3'b000} +: 8] <= in_byte;
    end else if (cmd.rep_step) begin
      held_vec <= tok2 ? (held_vec >> 16) : (held_vec >> 8);
    end
    if (cmd.out_load) begin
      unique case (cmd.src)
        jsu_pkg::SRC_SLOT: out_byte <= jsu_pkg::cp_byte(cur_item, bidx);
        jsu_pkg::SRC_REP:  out_byte <= rep_byte;
        default:           out_byte <= 8'd0;
      endcase
      byte_valid <= cmd.src != jsu_pkg::SRC_MARK;
      string_end <= cmd.out_end;
    end
  end

endmodule

// File: dv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;

  localparam int MaxWords      = 10;
  localparam int DrainSlack    = 20;
  localparam int WatchdogLimit = 2000;
  localparam int RandomBytes   = 52;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowX  = 8'h78;

  typedef enum logic [1:0] {
    ST_TEXT,
    ST_ESC,
    ST_HEX,
    ST_PAIR
  } unesc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       done;
  } utf8_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_end;

  json_string_unescape_utf8 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .string_end(string_end)
  );

  always #10 clk = ~clk;

  // decoder mirror
  unesc_state_t dec_state;
  logic [15:0]  dec_code;
  logic         dec_bad;
  logic [15:0]  dec_high;
  logic [7:0]   dec_held [0:5];
  logic [2:0]   dec_held_n;
  utf8_word_t   step_words [0:MaxWords-1];
  int           step_n;
  utf8_word_t   utf8_due [$];

  logic [7:0] token_bytes [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int bytes_sent = 0;
  int tokens_sent = 0;
  int words_checked = 0;
  int bare_marks = 0;
  int pairs_joined = 0;
  int quiet_cycles = 0;

  function automatic void clear_decoder();
    int i;
    dec_state  = ST_TEXT;
    dec_code   = '0;
    dec_bad    = 1'b0;
    dec_high   = '0;
    dec_held_n = '0;
    for (i = 0; i < 6; i++) dec_held[i] = '0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    if (step_n < MaxWords) begin
      step_words[step_n].data     = b;
      step_words[step_n].has_byte = 1'b1;
      step_words[step_n].done     = 1'b0;
      step_n++;
    end
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      emit_byte(jsu_pkg::Lead2 | {3'd0, cp[10:6]});
      emit_byte(jsu_pkg::Cont | {2'd0, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      emit_byte(jsu_pkg::Lead3 | {4'd0, cp[15:12]});
      emit_byte(jsu_pkg::Cont | {2'd0, cp[11:6]});
      emit_byte(jsu_pkg::Cont | {2'd0, cp[5:0]});
    end else begin
      emit_byte(jsu_pkg::Lead4 | {5'd0, cp[20:18]});
      emit_byte(jsu_pkg::Cont | {2'd0, cp[17:12]});
      emit_byte(jsu_pkg::Cont | {2'd0, cp[11:6]});
      emit_byte(jsu_pkg::Cont | {2'd0, cp[5:0]});
    end
  endfunction

  // {not_hex, value}
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b0, 4'(c - ChZero)};
    if (c >= ChLowA && c <= ChLowF) return {1'b0, 4'(c - ChLowA + 8'd10)};
    if (c >= ChUpA && c <= ChUpF) return {1'b0, 4'(c - ChUpA + 8'd10)};
    return 5'h10;
  endfunction

  function automatic void shift_hex(logic [7:0] c);
    logic [4:0] d;
    d = nibble_of(c);
    if (d[4]) dec_bad = 1'b1;
    else dec_code = {dec_code[11:0], d[3:0]};
  endfunction

  // returns 0 for the \u introducer
  function automatic logic esc_lookup(input logic [7:0] c, output logic [7:0] b);
    b = c;
    case (c)
      jsu_pkg::ChLowerN: b = jsu_pkg::ChNewline;
      jsu_pkg::ChLowerR: b = jsu_pkg::ChReturn;
      jsu_pkg::ChLowerT: b = jsu_pkg::ChTab;
      jsu_pkg::ChLowerB: b = jsu_pkg::ChBackspace;
      jsu_pkg::ChLowerF: b = jsu_pkg::ChFormFeed;
      default: ;
    endcase
    return c != jsu_pkg::ChLowerU;
  endfunction

  function automatic void take_text(logic [7:0] c, logic last);
    dec_state = ST_TEXT;
    if (c != jsu_pkg::ChBackslash) emit_byte(c);
    else if (last) emit_byte(jsu_pkg::ChBackslash);
    else dec_state = ST_ESC;
  endfunction

  function automatic void take_escape(logic [7:0] c);
    logic [7:0] b;
    dec_state = ST_TEXT;
    if (esc_lookup(c, b)) begin
      emit_byte(b);
    end else begin
      dec_state  = ST_HEX;
      dec_held_n = '0;
      dec_code   = '0;
      dec_bad    = 1'b0;
    end
  endfunction

  function automatic void finish_hex(logic [15:0] cp, logic bad);
    dec_state = ST_TEXT;
    if (bad) begin
      emit_byte(jsu_pkg::ChQuestion);
    end else if (cp >= jsu_pkg::SurHiMin && cp <= jsu_pkg::SurHiMax) begin
      dec_high   = cp;
      dec_state  = ST_PAIR;
      dec_held_n = '0;
      dec_code   = '0;
      dec_bad    = 1'b0;
    end else begin
      emit_code_point({5'd0, cp});
    end
  endfunction

  // held bytes decoded as plain tail text; any \u in them is dropped
  function automatic void replay_held_text();
    int k;
    int i;
    logic [7:0] c;
    logic [7:0] b;
    k = (dec_held_n > 3'd6) ? 6 : int'(dec_held_n);
    i = 0;
    while (i < k) begin
      c = dec_held[i];
      if (c != jsu_pkg::ChBackslash || i + 1 >= k) begin
        emit_byte(c);
      end else begin
        i++;
        if (esc_lookup(dec_held[i], b)) emit_byte(b);
      end
      i++;
    end
  endfunction

  function automatic void unescape_word(logic [7:0] c, logic last);
    logic [20:0] joined;
    int i;
    step_n = 0;
    case (dec_state)
      ST_ESC: take_escape(c);
      ST_HEX: begin
        shift_hex(c);
        if (dec_held_n < 3'd3) begin
          dec_held[dec_held_n] = c;
          dec_held_n++;
        end else begin
          dec_held_n = '0;
          finish_hex(dec_code, dec_bad);
        end
      end
      ST_PAIR: begin
        if (dec_held_n == 3'd0 && c != jsu_pkg::ChBackslash) begin
          emit_code_point({5'd0, dec_high});
          take_text(c, last);
        end else if (dec_held_n == 3'd1 && c != jsu_pkg::ChLowerU) begin
          emit_code_point({5'd0, dec_high});
          dec_held_n = '0;
          take_escape(c);
        end else if (dec_held_n < 3'd5) begin
          if (dec_held_n >= 3'd2) shift_hex(c);
          dec_held[dec_held_n] = c;
          dec_held_n++;
        end else begin
          shift_hex(c);
          dec_held_n = '0;
          if (!dec_bad && dec_code >= jsu_pkg::SurLoMin && dec_code <= jsu_pkg::SurLoMax) begin
            joined = jsu_pkg::SupplBase + {1'b0, dec_high[9:0], dec_code[9:0]};
            emit_code_point(joined);
            dec_state = ST_TEXT;
            pairs_joined++;
          end else begin
            emit_code_point({5'd0, dec_high});
            finish_hex(dec_code, dec_bad);
          end
        end
      end
      default: take_text(c, last);
    endcase
    if (last) begin
      if (dec_state == ST_HEX) begin
        replay_held_text();
      end else if (dec_state == ST_PAIR) begin
        emit_code_point({5'd0, dec_high});
        replay_held_text();
      end else if (dec_state == ST_ESC) begin
        emit_byte(jsu_pkg::ChBackslash);
      end
      clear_decoder();
      if (step_n == 0) begin
        step_words[0].data     = 8'h00;
        step_words[0].has_byte = 1'b0;
        step_words[0].done     = 1'b1;
        step_n = 1;
      end else begin
        step_words[step_n-1].done = 1'b1;
      end
    end
    for (i = 0; i < step_n; i++) utf8_due.push_back(step_words[i]);
  endfunction

  // input and output words are both sampled here, so predictions land before checks
  always @(posedge clk) begin : word_check
    utf8_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) unescape_word(in_byte, last_byte);
      if (out_valid && out_ready) begin
        words_checked++;
        if (!byte_valid) bare_marks++;
        if (utf8_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected word: got byte=%02h byte_valid=%0b string_end=%0b",
                   $time, out_byte, byte_valid, string_end);
        end else begin
          want = utf8_due.pop_front();
          if (out_byte !== want.data || byte_valid !== want.has_byte ||
              string_end !== want.done) begin
            err_count++;
            $display("%0t: word mismatch: expected byte=%02h byte_valid=%0b string_end=%0b",
                     $time, want.data, want.has_byte, want.done);
            $display("%0t:                got byte=%02h byte_valid=%0b string_end=%0b",
                     $time, out_byte, byte_valid, string_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d words still due",
               $time, quiet_cycles, utf8_due.size());
      $display("json_string_unescape_utf8 regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_token();
    int i;
    for (i = 0; i < token_bytes.size(); i++) begin
      send_word(token_bytes[i], i == token_bytes.size() - 1);
    end
    tokens_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] c;
    logic [4:0] d;
    c = 8'($urandom_range(255));
    d = nibble_of(c);
    while (!d[4]) begin
      c = 8'($urandom_range(255));
      d = nibble_of(c);
    end
    return c;
  endfunction

  // \u plus four digits of v; the digit at bad_pos (if 0..3) is replaced by bad_char
  function automatic void append_u(logic [15:0] v, logic [7:0] bad_char, int bad_pos);
    int k;
    logic [3:0] nib;
    logic [7:0] c;
    token_bytes.push_back(jsu_pkg::ChBackslash);
    token_bytes.push_back(jsu_pkg::ChLowerU);
    for (k = 0; k < 4; k++) begin
      nib = v[15 - 4*k -: 4];
      if (nib < 4'd10) c = ChZero + {4'd0, nib};
      else c = ($urandom_range(1) ? ChLowA : ChUpA) + {4'd0, nib} - 8'd10;
      token_bytes.push_back(k == bad_pos ? bad_char : c);
    end
  endfunction

  function automatic logic [15:0] pick_code16();
    case ($urandom_range(5))
      0: return 16'($urandom_range(16'h7F));
      1: return 16'($urandom_range(16'h7FF, 16'h80));
      2: return 16'($urandom_range(16'hD7FF, 16'h800));
      3: return 16'($urandom_range(16'hFFFF, 16'hE000));
      4: return 16'($urandom_range(16'hDFFF, 16'hDC00));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void add_segment();
    int kind;
    logic [7:0] c;
    logic [15:0] hi;
    kind = $urandom_range(99);
    if (kind < 30) begin
      c = 8'($urandom_range(255));
      if (c == jsu_pkg::ChBackslash && $urandom_range(1)) c = ChLowX;
      token_bytes.push_back(c);
    end else if (kind < 45) begin
      token_bytes.push_back(jsu_pkg::ChBackslash);
      case ($urandom_range(8))
        0: c = jsu_pkg::ChLowerN;
        1: c = jsu_pkg::ChLowerR;
        2: c = jsu_pkg::ChLowerT;
        3: c = jsu_pkg::ChLowerB;
        4: c = jsu_pkg::ChLowerF;
        5: c = ChQuote;
        6: c = jsu_pkg::ChBackslash;
        7: c = ChSlash;
        default: begin
          c = 8'($urandom_range(255));
          if (c == jsu_pkg::ChLowerU) c = ChLowX;
        end
      endcase
      token_bytes.push_back(c);
    end else if (kind < 65) begin
      append_u(pick_code16(), 8'h00, -1);
    end else if (kind < 80) begin
      append_u(16'($urandom_range(jsu_pkg::SurHiMax, jsu_pkg::SurHiMin)), 8'h00, -1);
      append_u(16'($urandom_range(jsu_pkg::SurLoMax, jsu_pkg::SurLoMin)), 8'h00, -1);
    end else if (kind < 88) begin
      hi = 16'($urandom_range(jsu_pkg::SurHiMax, jsu_pkg::SurHiMin));
      append_u(hi, 8'h00, -1);
      case ($urandom_range(3))
        0: begin
          c = 8'($urandom_range(255));
          token_bytes.push_back(c == jsu_pkg::ChBackslash ? ChLowX : c);
        end
        1: begin
          c = 8'($urandom_range(255));
          token_bytes.push_back(jsu_pkg::ChBackslash);
          token_bytes.push_back(c == jsu_pkg::ChLowerU ? ChLowX : c);
        end
        2: append_u(16'($urandom_range(16'hDBFF)), 8'h00, -1);
        default: append_u(16'($urandom_range(jsu_pkg::SurLoMax, jsu_pkg::SurLoMin)),
                          pick_nonhex(), $urandom_range(3));
      endcase
    end else if (kind < 95) begin
      append_u(pick_code16(), pick_nonhex(), $urandom_range(3));
    end else begin
      token_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_plain_bytes();
    token_bytes = {8'h00, 8'hFF, 8'h55};
    send_token();
  endtask

  // \t then a lone backslash as the final byte
  task automatic test_escapes();
    token_bytes = {jsu_pkg::ChBackslash, jsu_pkg::ChLowerT, jsu_pkg::ChBackslash};
    send_token();
  endtask

  task automatic test_unicode_escapes();
    token_bytes.delete();
    append_u(16'h0000, 8'h00, -1);
    send_token();
  endtask

  task automatic test_broken_escapes();
    // short \u at end of token
    token_bytes = {jsu_pkg::ChBackslash, jsu_pkg::ChLowerU, 8'h31, 8'h32};
    send_token();
    // a backslash among the hex digits is still eaten as a digit
    token_bytes.delete();
    append_u(16'h1234, jsu_pkg::ChBackslash, 1);
    token_bytes.push_back(ChLowX);
    send_token();
    // high surrogate left unpaired
    token_bytes.delete();
    append_u(jsu_pkg::SurHiMin, 8'h00, -1);
    token_bytes.push_back(ChLowA);
    send_token();
    // \u as the whole token gives a bare end marker
    token_bytes = {jsu_pkg::ChBackslash, jsu_pkg::ChLowerU};
    send_token();
  endtask

  task automatic test_random_tokens(input int send_pct, input int recv_pct, input int nbytes);
    int target;
    int n;
    logic [7:0] c;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    target        = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      token_bytes.delete();
      repeat ($urandom_range(5, 1)) add_segment();
      if ($urandom_range(99) < 20 && token_bytes.size() > 1) begin
        n = $urandom_range(token_bytes.size() - 1, 1);
        while (token_bytes.size() > n) c = token_bytes.pop_back();
      end
      send_token();
    end
    wait_drained();
  endtask

  initial begin
    clear_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_escapes();
    test_unicode_escapes();
    test_broken_escapes();
    wait_drained();
    test_random_tokens(0, 0, RandomBytes);
    test_random_tokens(63, 0, RandomBytes);
    test_random_tokens(0, 63, RandomBytes);
    test_random_tokens(24, 24, RandomBytes);
    if (utf8_due.size() != 0) begin
      err_count++;
      $display("%0t: %0d words never arrived, first expected byte=%02h",
               $time, utf8_due.size(), utf8_due[0].data);
    end
    $display("covered %0d tokens, %0d input bytes across four idle/stall mixes",
             tokens_sent, bytes_sent);
    $display("checked %0d output words, %0d surrogate pairs joined, %0d bare end markers",
             words_checked, pairs_joined, bare_marks);
    if (err_count == 0) begin
      $display("json_string_unescape_utf8 regression: pass");
    end else begin
      $display("json_string_unescape_utf8 regression: fail");
    end
    $finish;
  end

endmodule
